/* src/ufs_pkg.sv */
package ufs_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueueIdxW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [31:0] MagicLong  = 32'h2207_1970;
   localparam logic [15:0] Switch4Bit = 16'h00b8;
   localparam logic [15:0] Switch8Bit = 16'h00b7;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_WORD  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      CSR_LOAD_ADDRESS        = 2'd0,
      CSR_WORD_COUNT          = 2'd1,
      CSR_FOUR_BIT_MODE       = 2'd2,
      CSR_SEND_SWITCH_COMMAND = 2'd3
   } csr_index_type;

   typedef enum logic [8:0] {
      SEG_SW0      = 9'b0_0000_0001,
      SEG_SW1      = 9'b0_0000_0010,
      SEG_SW2      = 9'b0_0000_0100,
      SEG_ZERO     = 9'b0_0000_1000,
      SEG_MAGIC    = 9'b0_0001_0000,
      SEG_ADDR     = 9'b0_0010_0000,
      SEG_LEN      = 9'b0_0100_0000,
      SEG_DATA     = 9'b0_1000_0000,
      SEG_CHECKSUM = 9'b1_0000_0000
   } seg_type;

   typedef struct packed {
      logic [31:0] load_address;
      logic [29:0] word_count;
      logic        four_bit_mode;
      logic        send_switch_command;
   } cfg_type;

   typedef struct packed {
      logic        is_start;
      logic [31:0] data_word;
      logic [31:0] checksum;
      logic        append_checksum;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* src/ufs_front.sv */
module ufs_front
   import ufs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_func,
   input  logic [31:0]  req_data_word,
   output logic         req_stall,
   input  cfg_type      cfg,
   input  q_status_type q_status,
   output logic         push,
   output cmd_type      push_cmd
);

   logic        active_ff, active_in;
   logic [29:0] words_left_ff, words_left_in;
   logic [31:0] checksum_ff, checksum_in;
   logic        accept;
   logic [31:0] sum_next;
   logic [29:0] left_next;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign sum_next  = checksum_ff - req_data_word;
   assign left_next = words_left_ff - 30'd1;

   always_comb begin
      active_in     = active_ff;
      words_left_in = words_left_ff;
      checksum_in   = checksum_ff;
      push          = 1'b0;
      push_cmd.is_start        = (func_type'(req_func) == FUNC_START);
      push_cmd.data_word       = req_data_word;
      push_cmd.checksum        = 32'd0;
      push_cmd.append_checksum = 1'b0;
      if (accept) begin
         if (func_type'(req_func) == FUNC_START) begin
            if (!active_ff) begin
               push          = 1'b1;
               words_left_in = cfg.word_count;
               checksum_in   = 32'd0;
               active_in     = (cfg.word_count != 30'd0);
               push_cmd.append_checksum = (cfg.word_count == 30'd0);
            end
         end else if (active_ff) begin
            push          = 1'b1;
            checksum_in   = sum_next;
            words_left_in = left_next;
            active_in     = (left_next != 30'd0);
            push_cmd.checksum        = sum_next;
            push_cmd.append_checksum = (left_next == 30'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         words_left_ff <= 30'd0;
         checksum_ff   <= 32'd0;
      end else begin
         active_ff     <= active_in;
         words_left_ff <= words_left_in;
         checksum_ff   <= checksum_in;
      end
   end

endmodule

/* src/ufs_queue.sv */
module ufs_queue
   import ufs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   cmd_type                entries_ff [QueueDepth];
   logic [QueueIdxW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueueIdxW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_status.full  = (count_ff == QueueCntW'(QueueDepth));
   assign q_status.empty = (count_ff == '0);
   assign do_push  = push && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueueIdxW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueueIdxW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* src/ufs_back.sv */
module ufs_back
   import ufs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      head_cmd,
   input  q_status_type q_status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_data_lines,
   output logic         rsp_normal_handshake,
   output logic         rsp_last,
   output logic         rsp_frame_done
);

   function automatic logic [15:0] rotl16(input logic [15:0] w, input logic [3:0] amt);
      logic [31:0] t;
      t = {w, w} << amt;
      return t[31:16];
   endfunction

   logic        started_ff, started_in;
   seg_type     seg_ff, seg_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  data_lines_ff;
   logic        normal_ff, last_ff, frame_done_ff;

   seg_type     first_seg, cur_seg, next_seg;
   logic        is_switch, seg_end, item_end, advance, emit;
   logic [15:0] sw_word, sw_rot;
   logic [31:0] long_word;
   logic [7:0]  byte_sel, value;
   logic [1:0]  byte_idx;
   logic [2:0]  cnt_last;

   assign first_seg = !head_cmd.is_start ? SEG_DATA :
                      (cfg.send_switch_command ? SEG_SW0 : SEG_ZERO);
   assign cur_seg   = started_ff ? seg_ff : first_seg;
   assign is_switch = (cur_seg == SEG_SW0) || (cur_seg == SEG_SW1) || (cur_seg == SEG_SW2);

   always_comb begin
      case (cur_seg)
         SEG_SW2:      sw_word = cfg.four_bit_mode ? Switch4Bit : Switch8Bit;
         default:      sw_word = 16'h0000;
      endcase
   end

   assign sw_rot = rotl16(sw_word, 4'd3 + {cnt_ff, 1'b0});

   always_comb begin
      case (cur_seg)
         SEG_MAGIC:    long_word = MagicLong;
         SEG_ADDR:     long_word = cfg.load_address;
         SEG_LEN:      long_word = {cfg.word_count, 2'b00} + 32'd4;
         SEG_DATA:     long_word = head_cmd.data_word;
         SEG_CHECKSUM: long_word = head_cmd.checksum;
         default:      long_word = 32'd0;
      endcase
   end

   assign byte_idx = cfg.four_bit_mode ? cnt_ff[2:1] : cnt_ff[1:0];

   always_comb begin
      case (byte_idx)
         2'd0:    byte_sel = long_word[7:0];
         2'd1:    byte_sel = long_word[15:8];
         2'd2:    byte_sel = long_word[23:16];
         default: byte_sel = long_word[31:24];
      endcase
   end

   always_comb begin
      if (is_switch) begin
         value = {5'b00000, sw_rot[2:1], 1'b0};
      end else if (cfg.four_bit_mode) begin
         value = cnt_ff[0] ? {byte_sel[7:4], 4'h0} : {byte_sel[3:0], 4'h0};
      end else begin
         value = byte_sel;
      end
   end

   always_comb begin
      case (cur_seg)
         SEG_SW0:   next_seg = SEG_SW1;
         SEG_SW1:   next_seg = SEG_SW2;
         SEG_SW2:   next_seg = SEG_ZERO;
         SEG_ZERO:  next_seg = SEG_MAGIC;
         SEG_MAGIC: next_seg = SEG_ADDR;
         SEG_ADDR:  next_seg = SEG_LEN;
         default:   next_seg = SEG_CHECKSUM;
      endcase
   end

   assign cnt_last = (is_switch || cfg.four_bit_mode) ? 3'd7 : 3'd3;
   assign seg_end  = (cnt_ff == cnt_last);
   assign item_end = seg_end && ((cur_seg == SEG_CHECKSUM) ||
                     (((cur_seg == SEG_LEN) || (cur_seg == SEG_DATA)) &&
                      !head_cmd.append_checksum));

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = advance && !q_status.empty;
   assign pop     = emit && item_end;

   always_comb begin
      started_in   = started_ff;
      seg_in       = seg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         if (item_end) begin
            started_in = 1'b0;
            cnt_in     = 3'd0;
         end else if (seg_end) begin
            started_in = 1'b1;
            seg_in     = next_seg;
            cnt_in     = 3'd0;
         end else begin
            started_in = 1'b1;
            seg_in     = cur_seg;
            cnt_in     = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         seg_ff       <= SEG_ZERO;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         seg_ff       <= seg_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         data_lines_ff <= value;
         normal_ff     <= is_switch;
         last_ff       <= item_end;
         frame_done_ff <= seg_end && (cur_seg == SEG_CHECKSUM);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_data_lines       = data_lines_ff;
   assign rsp_normal_handshake = normal_ff;
   assign rsp_last             = last_ff;
   assign rsp_frame_done       = frame_done_ff;

endmodule

/* src/upload_frame_serializer.sv */
// Upload frame serializer: turns start and payload-word items into data-line values.
// Request channel (req_valid/req_stall): func 0 starts a frame, func 1 carries one
// payload word. Items that do not fit the frame state are taken and dropped.
// Response channel (rsp_valid/rsp_stall): one data-line value per transfer, with
// rsp_last on the final value of an item and rsp_frame_done on the final checksum value.
// Register port (csr_valid/csr_ready, always ready): write only while the block is idle.
// The first value of an item passes through the command queue and then the output
// register before it is valid, if the sequencer is idle and the receiver does not stall.
// The back-end sequencer and its output register give one value per cycle while the
// receiver does not stall and the queue is not empty; a payload word takes 8 values in
// 4-bit mode and 4 in 8-bit mode, plus 8 or 4 for the checksum after the last word; a
// start takes 16 to 64, the most with the switch command in 4-bit mode on an empty frame.
// A two-entry command queue parts the front end from the sequencer, so new items are
// taken while values still wait on the response side.
// Reset: registers return to their defaults, the queue empties and the frame goes idle.
// When the receiver stalls, the output register holds, the sequencer halts, the queue
// fills and then req_stall rises.
module upload_frame_serializer
   import ufs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_data_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_lines,
   output logic        rsp_normal_handshake,
   output logic        rsp_last,
   output logic        rsp_frame_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   cmd_type      push_cmd, head_cmd;
   logic         push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LOAD_ADDRESS:        cfg_in.load_address        = csr_data;
            CSR_WORD_COUNT:          cfg_in.word_count          = csr_data[29:0];
            CSR_FOUR_BIT_MODE:       cfg_in.four_bit_mode       = csr_data[0];
            CSR_SEND_SWITCH_COMMAND: cfg_in.send_switch_command = csr_data[0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.load_address        <= 32'h0000_4000;
         cfg_ff.word_count          <= 30'd0;
         cfg_ff.four_bit_mode       <= 1'b1;
         cfg_ff.send_switch_command <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ufs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_data_word (req_data_word),
      .req_stall     (req_stall),
      .cfg           (cfg_ff),
      .q_status      (q_status),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   ufs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   ufs_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head_cmd             (head_cmd),
      .q_status             (q_status),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_lines       (rsp_data_lines),
      .rsp_normal_handshake (rsp_normal_handshake),
      .rsp_last             (rsp_last),
      .rsp_frame_done       (rsp_frame_done)
   );

`ifndef SYNTHESIS
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last && !rsp_normal_handshake)
      else $error("frame done without last value");

   a_switch_value_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_handshake |->
         rsp_data_lines[7:3] == 5'd0 && !rsp_data_lines[0])
      else $error("switch value outside bits 2:1");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");
`endif

endmodule

/* bench/upload_frame_serializer_tb.sv */
`timescale 1ns / 1ps

module upload_frame_serializer_tb;
   import ufs_pkg::*;

   localparam int unsigned SettleCycles = 12;

   typedef struct {
      func_type    func;
      logic [31:0] word;
      bit          wait_drain;
   } upload_item_type;

   typedef struct packed {
      logic [7:0] data_lines;
      logic       normal_handshake;
      logic       last;
      logic       frame_done;
   } line_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_START;
   logic [31:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_data_lines;
   logic        rsp_normal_handshake;
   logic        rsp_last;
   logic        rsp_frame_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_LOAD_ADDRESS;
   logic [31:0] csr_data = '0;

   upload_item_type upload_items[$];
   line_type        pending_lines[$];

   cfg_type      shadow_cfg;
   logic         frame_active;
   logic [29:0]  words_left;
   logic [31:0]  run_sum;

   bit           lines_drained = 1'b1;
   int unsigned  items_sent;
   int unsigned  lines_checked;
   int unsigned  frames_closed;
   int unsigned  mismatches;

   upload_frame_serializer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_data_word        (req_data_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_lines       (rsp_data_lines),
      .rsp_normal_handshake (rsp_normal_handshake),
      .rsp_last             (rsp_last),
      .rsp_frame_done       (rsp_frame_done),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_line(logic [7:0] value, logic normal);
      line_type l;
      l.data_lines       = value;
      l.normal_handshake = normal;
      l.last             = 1'b0;
      l.frame_done       = 1'b0;
      pending_lines.push_back(l);
   endfunction

   function automatic void add_long(logic [31:0] w);
      logic [7:0] c;
      for (int b = 0; b < 4; b++) begin
         c = w[8*b +: 8];
         if (shadow_cfg.four_bit_mode) begin
            add_line({c[3:0], 4'h0}, 1'b0);
            add_line({c[7:4], 4'h0}, 1'b0);
         end else begin
            add_line(c, 1'b0);
         end
      end
   endfunction

   function automatic void close_frame();
      line_type tail;
      add_long(run_sum);
      tail = pending_lines[pending_lines.size() - 1];
      tail.frame_done = 1'b1;
      pending_lines[pending_lines.size() - 1] = tail;
      frame_active = 1'b0;
      words_left   = '0;
   endfunction

   function automatic void serialize_item(func_type f, logic [31:0] w);
      int unsigned first;
      logic [15:0] sw;
      logic [15:0] sw_words [3];
      line_type    tail;
      first = pending_lines.size();
      if (f == FUNC_START) begin
         if (frame_active)
            return;
         if (shadow_cfg.send_switch_command) begin
            sw_words[0] = 16'h0;
            sw_words[1] = 16'h0;
            sw_words[2] = shadow_cfg.four_bit_mode ? Switch4Bit : Switch8Bit;
            foreach (sw_words[k]) begin
               sw = {sw_words[k][12:0], sw_words[k][15:13]};
               repeat (8) begin
                  add_line({5'b0, sw[2:1], 1'b0}, 1'b1);
                  sw = {sw[13:0], sw[15:14]};
               end
            end
         end
         add_long(32'h0);
         add_long(MagicLong);
         add_long(shadow_cfg.load_address);
         add_long({shadow_cfg.word_count, 2'b00} + 32'd4);
         frame_active = 1'b1;
         words_left   = shadow_cfg.word_count;
         run_sum      = '0;
         if (words_left == '0)
            close_frame();
      end else begin
         if (!frame_active)
            return;
         run_sum = run_sum - w;
         add_long(w);
         words_left = words_left - 30'd1;
         if (words_left == '0)
            close_frame();
      end
      if (pending_lines.size() > first) begin
         tail = pending_lines[pending_lines.size() - 1];
         tail.last = 1'b1;
         pending_lines[pending_lines.size() - 1] = tail;
      end
   endfunction

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin : req_driver
      upload_item_type it;
      bit              taken;
      bit              next_valid;
      int unsigned     gap_left;
      int unsigned     burst_left;
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   = 0;
         burst_left = $urandom_range(1, 16);
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            serialize_item(func_type'(req_func), req_data_word);
            items_sent++;
         end
         if (!req_valid || taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (upload_items.size() > 0 &&
                         (!upload_items[0].wait_drain || (lines_drained && !taken))) begin
               it = upload_items.pop_front();
               req_func      <= it.func;
               req_data_word <= it.word;
               next_valid    = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   always @(negedge clock)
      lines_drained = (pending_lines.size() == 0);

   // receiver: check each transfer and stall on a changing pattern
   always @(posedge clock) begin : rsp_monitor
      line_type    want;
      line_type    got;
      int unsigned stall_mode;
      int unsigned mode_left;
      int unsigned tick;
      bit          next_stall;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode = 0;
         mode_left  = 100;
         tick       = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.data_lines       = rsp_data_lines;
            got.normal_handshake = rsp_normal_handshake;
            got.last             = rsp_last;
            got.frame_done       = rsp_frame_done;
            if (pending_lines.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transfer data_lines=%02h normal=%b last=%b done=%b",
                        $time, got.data_lines, got.normal_handshake, got.last,
                        got.frame_done);
            end else begin
               want = pending_lines.pop_front();
               lines_checked++;
               if (got !== want) begin
                  mismatches++;
                  $display({"%0t: mismatch expected data_lines=%02h normal=%b last=%b done=%b",
                            " actual data_lines=%02h normal=%b last=%b done=%b"},
                           $time, want.data_lines, want.normal_handshake, want.last,
                           want.frame_done, got.data_lines, got.normal_handshake,
                           got.last, got.frame_done);
               end
            end
            if (got.frame_done === 1'b1)
               frames_closed++;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         tick++;
         case (stall_mode)
            1: next_stall = ($urandom_range(0, 3) == 0);
            2: next_stall = ($urandom_range(0, 3) != 0);
            3: next_stall = ((tick % 8) < 3);
            default: next_stall = 1'b0;
         endcase
         rsp_stall <= next_stall;
      end
   end

   task automatic settle();
      do @(negedge clock);
      while (upload_items.size() != 0 || req_valid || pending_lines.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_LOAD_ADDRESS:        shadow_cfg.load_address        = value;
         CSR_WORD_COUNT:          shadow_cfg.word_count          = value[29:0];
         CSR_FOUR_BIT_MODE:       shadow_cfg.four_bit_mode       = value[0];
         CSR_SEND_SWITCH_COMMAND: shadow_cfg.send_switch_command = value[0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
   endtask

   task automatic push_item(func_type f, logic [31:0] w, bit wait_drain = 1'b0);
      upload_item_type it;
      it.func       = f;
      it.word       = w;
      it.wait_drain = wait_drain;
      upload_items.push_back(it);
   endtask

   // one frame with random content; sometimes a stray start inside, a cut, or a stray word
   task automatic push_frame(int unsigned count, inout int unsigned added);
      push_item(FUNC_START, $urandom(), $urandom_range(0, 19) == 0);
      added++;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            push_item(FUNC_START, $urandom());
            added++;
         end
         if ($urandom_range(0, 24) == 0)
            break;
         push_item(FUNC_WORD, $urandom());
         added++;
      end
      if ($urandom_range(0, 11) == 0) begin
         push_item(FUNC_WORD, $urandom());
         added++;
      end
   endtask

   initial begin : stimulus
      int unsigned added;
      logic [29:0] count;
      logic [31:0] addr;
      shadow_cfg.load_address        = 32'h0000_4000;
      shadow_cfg.word_count          = '0;
      shadow_cfg.four_bit_mode       = 1'b1;
      shadow_cfg.send_switch_command = 1'b1;
      frame_active = 1'b0;
      words_left   = '0;
      run_sum      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // word while idle, then an empty frame on reset settings
      push_item(FUNC_WORD, 32'hFFFF_FFFF);
      push_item(FUNC_START, 32'h0);
      settle();
      write_reg(CSR_LOAD_ADDRESS, 32'hFFFF_FFFF);
      write_reg(CSR_WORD_COUNT, 32'd3);
      end_writes();
      push_item(FUNC_START, 32'h0);
      push_item(FUNC_START, 32'hFFFF_FFFF);
      push_item(FUNC_WORD, 32'h0, 1'b1);
      push_item(FUNC_WORD, 32'hFFFF_FFFF);
      push_item(FUNC_WORD, 32'h1234_5678);
      settle();
      write_reg(CSR_LOAD_ADDRESS, 32'h0);
      write_reg(CSR_WORD_COUNT, 32'd2);
      write_reg(CSR_FOUR_BIT_MODE, 32'd0);
      write_reg(CSR_SEND_SWITCH_COMMAND, 32'd0);
      end_writes();
      push_item(FUNC_START, 32'hDEAD_BEEF);
      push_item(FUNC_WORD, 32'hA5A5_A5A5);
      push_item(FUNC_WORD, 32'h5A5A_5A5A);
      push_item(FUNC_WORD, 32'h0000_0001);
      settle();
      write_reg(CSR_WORD_COUNT, 32'd1);
      write_reg(CSR_SEND_SWITCH_COMMAND, 32'd1);
      end_writes();
      push_item(FUNC_START, 32'h0);
      push_item(FUNC_WORD, 32'h8000_0001);
      settle();
      write_reg(CSR_WORD_COUNT, 32'd4);
      write_reg(CSR_FOUR_BIT_MODE, 32'd1);
      write_reg(CSR_SEND_SWITCH_COMMAND, 32'd0);
      end_writes();
      push_item(FUNC_START, 32'h0);
      push_item(FUNC_WORD, 32'h0000_0001);
      push_item(FUNC_WORD, 32'h7FFF_FFFF);
      // mode switch mid-frame; word_count stays latched
      settle();
      write_reg(CSR_FOUR_BIT_MODE, 32'd0);
      write_reg(CSR_WORD_COUNT, 32'd0);
      end_writes();
      push_item(FUNC_WORD, 32'hFEDC_BA98);
      push_item(FUNC_WORD, 32'h0F0F_0F0F);

      for (int p = 0; p < 12; p++) begin
         settle();
         case ($urandom_range(0, 4))
            0: addr = 32'h0;
            1: addr = 32'hFFFF_FFFF;
            default: addr = $urandom();
         endcase
         count = ($urandom_range(0, 7) == 0) ? 30'($urandom_range(8, 14)) :
                                               30'($urandom_range(0, 5));
         write_reg(CSR_LOAD_ADDRESS, addr);
         write_reg(CSR_WORD_COUNT, {2'b00, count});
         write_reg(CSR_FOUR_BIT_MODE, $urandom_range(0, 1));
         write_reg(CSR_SEND_SWITCH_COMMAND, $urandom_range(0, 1));
         end_writes();
         added = 0;
         while (added < 22)
            push_frame(count, added);
      end

      // close any frame left open, then the largest word count whose length value does not wrap
      settle();
      repeat (words_left) push_item(FUNC_WORD, $urandom());
      settle();
      write_reg(CSR_LOAD_ADDRESS, $urandom());
      write_reg(CSR_WORD_COUNT, 32'h3FFF_FFFE);
      write_reg(CSR_FOUR_BIT_MODE, $urandom_range(0, 1));
      end_writes();
      push_item(FUNC_START, $urandom());
      repeat (4) push_item(FUNC_WORD, $urandom());
      settle();
      repeat (2 * SettleCycles) @(posedge clock);

      $display("Summary: %0d items transferred, %0d line values checked, %0d frames closed,",
               items_sent, lines_checked, frames_closed);
      $display("  both transfer modes, with and without switch command, ignored items included");
      if (mismatches == 0 && pending_lines.size() == 0) begin
         $display("** upload_frame_serializer: PASSED **");
      end else begin
         $display("%0t: %0d mismatches, %0d expected values never arrived",
                  $time, mismatches, pending_lines.size());
         $display("** upload_frame_serializer: FAILED **");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("%0t: timeout, %0d expected values outstanding", $time, pending_lines.size());
      $display("** upload_frame_serializer: FAILED **");
      $finish;
   end

endmodule
